>>> design/hbtp_pkg.sv
// Shared types and constants for the hashed block test pattern generator.
// No dependencies; imported by hbtp_lane and hashed_block_test_pattern.
`default_nettype none

package hbtp_pkg;

  // Word widths fixed by the stream format
  localparam int OFF_W  = 18;
  localparam int POS_W  = OFF_W + 1;
  localparam int IDX_W  = 4;
  localparam int HASH_W = 32;

  // Byte-folded hash fits here: 4 bytes * 255 * 15 < 2^14
  localparam int SUM_W = 14;

  // Hash lane depth in register stages
  localparam int LANE_LAT = 8;

  // Front end depth: divide by width, fix the remainder, form both pixel coordinates
  localparam int FRONT_LAT = 3;

  localparam logic [HASH_W-1:0] SEED_MUL = 32'd2654435761;
  localparam logic [HASH_W-1:0] BX_MUL   = 32'd73856093;
  localparam logic [HASH_W-1:0] BY_MUL   = 32'd19349663;
  localparam logic [HASH_W-1:0] MIX1_MUL = 32'h7feb352d;
  localparam logic [HASH_W-1:0] MIX2_MUL = 32'h846ca68b;

  typedef logic [IDX_W-1:0]  hbtp_idx_t;
  typedef logic [HASH_W-1:0] hbtp_hash_t;

endpackage

`default_nettype wire

>>> design/hbtp_lane.sv
// One pixel hash lane: border test, block coordinates, hash and palette reduction.
// Depends on hbtp_pkg; instantiated twice by hashed_block_test_pattern.
`default_nettype none

module hbtp_lane
  import hbtp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 800,
  parameter int IMAGE_HEIGHT = 480,
  parameter int BLOCK_SIZE   = 40,
  parameter int PALETTE_SIZE = 7,
  parameter int BORDER_WIDTH = 4,
  parameter int COL_W        = 10,
  parameter int ROW_W        = 9
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [COL_W-1:0] col,
  input  wire logic [ROW_W-1:0] row,
  input  wire logic             off_frame,
  input  wire hbtp_hash_t       seed_mix,
  output hbtp_idx_t             idx
);

  localparam int DIV_K = 24;
  localparam logic [31:0] RECIP_B = 32'((64'd1 << DIV_K) / BLOCK_SIZE);
  localparam int MOD_K = 20;
  localparam logic [31:0] RECIP_P = 32'((64'd1 << MOD_K) / PALETTE_SIZE);
  localparam logic [31:0] FOLD0 = 32'(64'd1 % PALETTE_SIZE);
  localparam logic [31:0] FOLD1 = 32'((64'd1 << 8) % PALETTE_SIZE);
  localparam logic [31:0] FOLD2 = 32'((64'd1 << 16) % PALETTE_SIZE);
  localparam logic [31:0] FOLD3 = 32'((64'd1 << 24) % PALETTE_SIZE);

  // Stage 1: border test, block quotient estimate
  logic [COL_W-1:0] col1_r, bxq1_r;
  logic [ROW_W-1:0] row1_r, byq1_r;
  logic             z1_r;
  // Stage 2: remainders
  logic [COL_W-1:0] bxq2_r, rx2_r;
  logic [ROW_W-1:0] byq2_r, ry2_r;
  logic             z2_r;
  // Stages 3..8: hash, byte fold and palette reduction
  hbtp_hash_t       h3_r, a4_r, b5_r;
  logic             z3_r, z4_r, z5_r, z6_r, z7_r;
  logic [SUM_W-1:0] s6_r, s7_r, mq7_r;
  hbtp_idx_t        idx8_r;

  logic [47:0]      prod_x, prod_y;
  logic             border;
  logic [COL_W-1:0] rx_nxt;
  logic [ROW_W-1:0] ry_nxt;
  logic [31:0]      bx, by;
  hbtp_hash_t       h_nxt, a_nxt, b_nxt, v6;
  logic [SUM_W-1:0] s_nxt;
  logic [39:0]      prod_m;
  logic [SUM_W-1:0] r8;
  hbtp_idx_t        idx_nxt;

  always_comb begin
    border = (32'(col) < BORDER_WIDTH) || (32'(row) < BORDER_WIDTH) ||
             (32'(col) + BORDER_WIDTH >= IMAGE_WIDTH) ||
             (32'(row) + BORDER_WIDTH >= IMAGE_HEIGHT);
    prod_x = 48'(col) * 48'(RECIP_B);
    prod_y = 48'(row) * 48'(RECIP_B);
  end

  assign rx_nxt = col1_r - COL_W'(32'(bxq1_r) * BLOCK_SIZE);
  assign ry_nxt = row1_r - ROW_W'(32'(byq1_r) * BLOCK_SIZE);

  // Quotient estimate is at most one short
  always_comb begin
    bx = 32'(bxq2_r) + ((32'(rx2_r) >= BLOCK_SIZE) ? 32'd1 : 32'd0);
    by = 32'(byq2_r) + ((32'(ry2_r) >= BLOCK_SIZE) ? 32'd1 : 32'd0);
    h_nxt = seed_mix + bx * BX_MUL + by * BY_MUL;
    a_nxt = (h3_r ^ (h3_r >> 16)) * MIX1_MUL;
    b_nxt = (a4_r ^ (a4_r >> 15)) * MIX2_MUL;
    v6    = b5_r ^ (b5_r >> 16);
    // Fold the bytes: each weight is 256^i reduced by the palette size
    s_nxt = SUM_W'(32'(v6[7:0]) * FOLD0 + 32'(v6[15:8]) * FOLD1 +
                   32'(v6[23:16]) * FOLD2 + 32'(v6[31:24]) * FOLD3);
    prod_m = 40'(s6_r) * 40'(RECIP_P);
  end

  always_comb begin
    r8 = s7_r - SUM_W'(32'(mq7_r) * PALETTE_SIZE);
    if (32'(r8) >= PALETTE_SIZE) begin
      r8 = r8 - SUM_W'(PALETTE_SIZE);
    end
    idx_nxt = z7_r ? '0 : IDX_W'(r8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col1_r <= col;
      row1_r <= row;
      bxq1_r <= prod_x[DIV_K +: COL_W];
      byq1_r <= prod_y[DIV_K +: ROW_W];
      z1_r   <= off_frame | border;

      bxq2_r <= bxq1_r;
      byq2_r <= byq1_r;
      rx2_r  <= rx_nxt;
      ry2_r  <= ry_nxt;
      z2_r   <= z1_r;

      h3_r   <= h_nxt;
      z3_r   <= z2_r;
      a4_r   <= a_nxt;
      z4_r   <= z3_r;
      b5_r   <= b_nxt;
      z5_r   <= z4_r;
      s6_r   <= s_nxt;
      z6_r   <= z5_r;
      s7_r   <= s6_r;
      mq7_r  <= prod_m[MOD_K +: SUM_W];
      z7_r   <= z6_r;
      idx8_r <= idx_nxt;
    end
  end

  assign idx = idx8_r;

endmodule

`default_nettype wire

>>> design/hashed_block_test_pattern.sv
// Hashed block test pattern: one packed panel byte per accepted offset word.
// Pipeline: 11 register stages (3 front-end stages that split the pixel index
// into row and column, then 8 stages in each of two hash lanes); a taken word
// shows on out_tvalid once it reaches the last stage.
// Throughput: one word per clock unless the output stalls; the depth is set by
// the two chained 32-bit multipliers of the avalanche hash and the reciprocal
// multipliers that replace the divides.
// Input: in_tdata carries byte_offset, in_tlast marks the last byte of a request.
// Output: out_tdata carries the pixel byte (first pixel in the high nibble),
// out_tuser flags an offset past the frame payload (byte is then zero), and
// out_tlast echoes in_tlast.
// Seed: cfg_wr_en writes cfg_wr_data; write it only while no word is in flight.
// Reset: the pipeline empties and the seed returns to zero.
// Stall: while the output word waits, the whole pipeline holds and in_tready
// is low; nothing is dropped or repeated.
`default_nettype none

module hashed_block_test_pattern
  import hbtp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 800,
  parameter int IMAGE_HEIGHT = 480,
  parameter int BLOCK_SIZE   = 40,
  parameter int PALETTE_SIZE = 7,
  parameter int BORDER_WIDTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // [17:0] byte_offset, [23:18] zero
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] pixel_byte
  output logic             out_tuser,   // [0] out_of_range
  output logic             out_tlast
);

  localparam int COL_W = $clog2(IMAGE_WIDTH + 1);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT + 1);
  localparam int DEPTH = FRONT_LAT + LANE_LAT;
  localparam logic [31:0] PIXEL_COUNT = 32'(IMAGE_WIDTH * IMAGE_HEIGHT);
  localparam logic [31:0] PAYLOAD     = (PIXEL_COUNT + 32'd1) / 32'd2;
  localparam logic [31:0] RECIP_W     = 32'((64'd1 << 32) / IMAGE_WIDTH);

  logic             en;
  logic [DEPTH-1:0] vld_r, last_r, oor_r;
  hbtp_hash_t       seed_r, seed_mix_r;

  logic [POS_W-1:0] pos;
  logic [50:0]      prod_w;

  logic [POS_W-1:0] pos1_r, q1_r;
  logic             za1_r, zb1_r;
  logic [POS_W-1:0] q2_r;
  logic [COL_W:0]   rem2_r;
  logic             za2_r, zb2_r;
  logic [COL_W-1:0] cola3_r, colb3_r;
  logic [ROW_W-1:0] rowa3_r, rowb3_r;
  logic             za3_r, zb3_r;

  logic [POS_W-1:0] rem_full;
  logic [COL_W-1:0] cola, colb;
  logic [POS_W-1:0] rowa, rowb;
  hbtp_idx_t        idx_a, idx_b;

  // Advance whenever the output slot is free or being taken
  assign en        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  assign pos    = {in_tdata[OFF_W-1:0], 1'b0};
  assign prod_w = 51'(pos) * 51'(RECIP_W);

  assign rem_full = pos1_r - POS_W'(32'(q1_r) * IMAGE_WIDTH);

  // Quotient from the reciprocal may be one short: fix, then step to the second pixel
  always_comb begin
    if (32'(rem2_r) >= IMAGE_WIDTH) begin
      cola = COL_W'(32'(rem2_r) - IMAGE_WIDTH);
      rowa = q2_r + POS_W'(1);
    end else begin
      cola = rem2_r[COL_W-1:0];
      rowa = q2_r;
    end
    if (32'(cola) + 32'd1 == IMAGE_WIDTH) begin
      colb = '0;
      rowb = rowa + POS_W'(1);
    end else begin
      colb = cola + COL_W'(1);
      rowb = rowa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      seed_mix_r <= '0;
      vld_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      seed_mix_r <= seed_r * SEED_MUL;
      if (en) begin
        vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r  <= {last_r[DEPTH-2:0], in_tlast};
      oor_r   <= {oor_r[DEPTH-2:0], 32'(in_tdata[OFF_W-1:0]) >= PAYLOAD};

      pos1_r  <= pos;
      q1_r    <= prod_w[32 +: POS_W];
      za1_r   <= 32'(pos) >= PIXEL_COUNT;
      zb1_r   <= 32'(pos) + 32'd1 >= PIXEL_COUNT;

      q2_r    <= q1_r;
      rem2_r  <= rem_full[COL_W:0];
      za2_r   <= za1_r;
      zb2_r   <= zb1_r;

      cola3_r <= cola;
      colb3_r <= colb;
      rowa3_r <= rowa[ROW_W-1:0];
      rowb3_r <= rowb[ROW_W-1:0];
      za3_r   <= za2_r;
      zb3_r   <= zb2_r;
    end
  end

  hbtp_lane #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .BLOCK_SIZE  (BLOCK_SIZE),
    .PALETTE_SIZE(PALETTE_SIZE),
    .BORDER_WIDTH(BORDER_WIDTH),
    .COL_W       (COL_W),
    .ROW_W       (ROW_W)
  ) u_lane_a (
    .clk      (clk),
    .en       (en),
    .col      (cola3_r),
    .row      (rowa3_r),
    .off_frame(za3_r),
    .seed_mix (seed_mix_r),
    .idx      (idx_a)
  );

  hbtp_lane #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .BLOCK_SIZE  (BLOCK_SIZE),
    .PALETTE_SIZE(PALETTE_SIZE),
    .BORDER_WIDTH(BORDER_WIDTH),
    .COL_W       (COL_W),
    .ROW_W       (ROW_W)
  ) u_lane_b (
    .clk      (clk),
    .en       (en),
    .col      (colb3_r),
    .row      (rowb3_r),
    .off_frame(zb3_r),
    .seed_mix (seed_mix_r),
    .idx      (idx_b)
  );

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {idx_a, idx_b};
  assign out_tuser  = oor_r[DEPTH-1];
  assign out_tlast  = last_r[DEPTH-1];

`ifndef SYNTHESIS
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 8'd0))
    else $error("out-of-range word carries a nonzero byte");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((32'(out_tdata[3:0]) < PALETTE_SIZE) &&
                    (32'(out_tdata[7:4]) < PALETTE_SIZE)))
    else $error("palette index out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable(vld_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hashed_block_test_pattern: streams byte offsets in,
// predicts each packed pixel byte in the bench and compares it field by field.
// Depends on hbtp_pkg and the hashed_block_test_pattern RTL only.

module testbench;
  import hbtp_pkg::*;

  localparam int IMG_W    = 800;
  localparam int IMG_H    = 480;
  localparam int BLK      = 40;
  localparam int PALETTE  = 7;
  localparam int BORDER   = 4;
  localparam int PIXELS   = IMG_W * IMG_H;
  localparam int PAYLOAD  = (PIXELS + 1) / 2;
  localparam int LATENCY  = FRONT_LAT + LANE_LAT;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             last;
  } offset_word_t;

  typedef struct packed {
    logic [7:0] pixels;
    logic       out_of_range;
    logic       last;
  } panel_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // [17:0] byte_offset, [23:18] zero
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] pixel_byte
  logic        out_tuser;         // [0] out_of_range
  logic        out_tlast;

  offset_word_t offsets_to_send[$];
  panel_byte_t  bytes_due[$];
  logic [31:0]  seed_now = '0;
  logic         steady = 1'b0;
  int           words_queued = 0;
  int           words_checked = 0;
  int           past_payload = 0;
  int           mismatches = 0;
  int           seed_settings = 1;
  int           cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 0;
  int           phase;
  int           added;

  hashed_block_test_pattern dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] palette_index_at(input logic [31:0] pos,
                                                  input logic [31:0] seed);
    logic [31:0] col, row, h;
    if (pos >= PIXELS) return '0;
    col = pos % IMG_W;
    row = pos / IMG_W;
    if (col < BORDER || row < BORDER || col + BORDER >= IMG_W || row + BORDER >= IMG_H)
      return '0;
    h = seed * SEED_MUL + (col / BLK) * BX_MUL + (row / BLK) * BY_MUL;
    h = h ^ (h >> 16);
    h = h * MIX1_MUL;
    h = h ^ (h >> 15);
    h = h * MIX2_MUL;
    h = h ^ (h >> 16);
    return 4'(h % PALETTE);
  endfunction

  function automatic panel_byte_t panel_byte_for(input offset_word_t w,
                                                 input logic [31:0] seed);
    panel_byte_t r;
    logic [31:0] pos;
    r.last = w.last;
    r.out_of_range = (w.offset >= PAYLOAD);
    r.pixels = '0;
    if (!r.out_of_range) begin
      pos = 32'(w.offset) * 2;
      r.pixels = {palette_index_at(pos, seed), palette_index_at(pos + 1, seed)};
    end
    return r;
  endfunction

  // Driver: advance to the next pending word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        bytes_due.push_back(panel_byte_for({in_tdata[OFF_W-1:0], in_tlast}, seed_now));
        if (in_tdata[OFF_W-1:0] >= PAYLOAD) past_payload++;
      end
      if (!in_tvalid || in_tready) begin
        if (offsets_to_send.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
          offset_word_t w;
          w = offsets_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, w.offset};
          in_tlast  <= w.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus one long hold so the pipeline backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && words_checked >= 400) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  // Monitor: compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      panel_byte_t want;
      words_checked++;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixels=%02h oor=%0b last=%0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = bytes_due.pop_front();
        if (want.pixels !== out_tdata || want.out_of_range !== out_tuser ||
            want.last !== out_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at word %0d: expected pixels=%02h oor=%0b last=%0b, got %02h %0b %0b",
                     words_checked - 1, want.pixels, want.out_of_range, want.last,
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words back",
               cycles, words_checked, words_queued);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_word(input int offset, input logic last);
    offset_word_t w;
    w.offset = OFF_W'(offset);
    w.last   = last;
    offsets_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_checked != words_queued) @(posedge clk);
  endtask

  task automatic load_seed(input logic [31:0] seed);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    seed_now = seed;
    seed_settings++;
  endtask

  // Mostly runs of consecutive offsets ending in a last marker; some cross the
  // end of the payload, a few are unrelated offsets with a random marker.
  task automatic queue_request(output int count);
    int len, start, kind;
    len  = $urandom_range(16, 1);
    kind = $urandom_range(99);
    if (kind < 80) begin
      start = $urandom_range(PAYLOAD - 1, 0);
    end else if (kind < 90) begin
      start = $urandom_range(PAYLOAD + 4, PAYLOAD - 12);
    end else begin
      for (int i = 0; i < len; i++)
        queue_word($urandom_range((1 << OFF_W) - 1, 0), 1'($urandom_range(1)));
      count = len;
      return;
    end
    for (int i = 0; i < len; i++)
      queue_word((start + i) & ((1 << OFF_W) - 1), i == len - 1);
    count = len;
  endtask

  task automatic queue_directed();
    queue_word(0, 1'b0);                          // top-left corner, border
    queue_word(1, 1'b1);
    queue_word(1601, 1'b0);                       // left border of first inner row
    queue_word(1602, 1'b0);                       // first inner pixels
    queue_word(1603, 1'b1);
    queue_word(1997, 1'b0);                       // last inner pair of the row
    queue_word(1998, 1'b1);                       // right border
    queue_word(15650, 1'b0);                      // block row change, rows 39/40
    queue_word(16050, 1'b1);
    queue_word(40019, 1'b0);                      // block column change, cols 39/40
    queue_word(40020, 1'b1);
    queue_word(131072, 1'b0);
    queue_word(190200, 1'b0);                     // last inner row
    queue_word(190600, 1'b1);                     // bottom border
    queue_word(PAYLOAD - 1, 1'b0);                // last byte of the frame
    queue_word(PAYLOAD, 1'b1);                    // first offset past payload
    queue_word(PAYLOAD + 1, 1'b0);
    queue_word((1 << OFF_W) - 1, 1'b1);           // largest offset
    queue_word(87381, 1'b0);
    queue_word(174762, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // seed from reset
    queue_directed();
    load_seed(32'hFFFF_FFFF);
    queue_directed();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          load_seed(32'h0000_0000);
        end
        1: begin
          load_seed(32'h8000_0000);
        end
        default: begin
          load_seed($urandom);
        end
      endcase
      // one phase runs with no idling on either side
      @(posedge clk);
      steady <= (phase == 3);
      added = 0;
      while (added < 260) begin
        int n;
        queue_request(n);
        added += n;
      end
    end

    wait_drained();
    repeat (3 * LATENCY) @(posedge clk);
    $display("checked %0d pixel bytes (%0d past the payload) under %0d seed settings",
             words_checked, past_payload, seed_settings);
    $display("receiver hold of %0d cycles applied: %0b", HOLD_CYCLES, hold_done);
    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, bytes_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
